### hw/rtl/orp_pkg.sv
// shared types, character codes and helper functions for the orp/ph report parser
package orp_pkg;

    // parse position through the report pattern
    typedef enum logic [4:0] {
        POS_LEAD  = 5'd0,
        POS_R     = 5'd1,
        POS_P     = 5'd2,
        POS_SL1   = 5'd3,
        POS_O1    = 5'd4,
        POS_O2    = 5'd5,
        POS_O3    = 5'd6,
        POS_O4    = 5'd7,
        POS_SEP   = 5'd8,
        POS_H     = 5'd9,
        POS_SL2   = 5'd10,
        POS_PH1   = 5'd11,
        POS_DOT67 = 5'd12,
        POS_F67   = 5'd13,
        POS_DOT8  = 5'd14,
        POS_F8    = 5'd15,
        POS_F8B   = 5'd16,
        POS_DONE  = 5'd17
    } pos_t;

    // configuration register indexes
    localparam logic REG_MIN_LENGTH = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    localparam logic [7:0] MIN_LENGTH_RESET = 8'd13;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd32;
    localparam logic [7:0] COUNT_MAX        = 8'd255;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_R     = 8'h52;

    localparam logic [9:0] PH_MAX    = 10'd820;
    localparam logic [9:0] ORP_MAX   = 10'd999;
    localparam logic [9:0] ORP_MIN   = 10'd20;

    typedef struct packed {
        logic [9:0] orp_millivolts;
        logic [9:0] ph_hundredths;
        logic       malformed;
    } result_t;

    function automatic logic is_trim_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // vertical tab is trimmed but does not separate the two parts
    function automatic logic is_sep_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
               (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

endpackage

### hw/rtl/orp_ph_report_parser_unit.sv
// orp/ph report parser: character stream in, one parsed result per message out
//
// Input channel (s_): one character word per handshake, s_end_of_message on the
// last character of a report. Leading and trailing whitespace is trimmed and the
// text must read ORP/<value>, separator whitespace, PH/<value>.
// Result channel (m_): one word per message, carrying ORP in millivolts, pH in
// hundredths and a malformed flag; on a malformed message the last good values
// are repeated.
// Configuration: cfg_we writes cfg_data into the register chosen by cfg_index
// (0 = minimum trimmed length, 1 = maximum trimmed length) in the same cycle.
// Throughput: one character per cycle while s_ready is high. The result word is
// registered, and waits in the skid stage while the result register is held.
// Reset (aresetn low, synchronous) clears the parse state, the last good values,
// and both length registers to 13 and 32; the result channel empties.
// Stalls: the result register has a skid stage behind it, so characters keep
// flowing while a result waits; s_ready drops only when a second result is held
// and the receiver has still not taken the first.
module orp_ph_report_parser_unit
    import orp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [9:0] m_orp_millivolts,
    output logic [9:0] m_ph_hundredths,
    output logic       m_malformed
);

    logic [7:0] min_length_reg;
    logic [7:0] max_length_reg;

    pos_t       pos_reg, pos_next;
    logic       failed_reg, failed_next;
    logic [9:0] orp_acc_reg, orp_acc_next;
    logic [9:0] ph_acc_reg, ph_acc_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] pending_reg, pending_next;
    logic [9:0] good_orp_reg, good_orp_next;
    logic [9:0] good_ph_reg, good_ph_next;

    result_t    out_reg, skid_reg, result;
    logic       out_valid_reg, skid_valid_reg;

    logic       s_fire, emit, bad;
    logic       trim, sep, dig, started, ok;
    logic [7:0] c;
    logic [3:0] d;
    logic [8:0] count_sum;
    pos_t       adv_pos;
    logic [9:0] adv_orp, adv_ph;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign emit    = s_fire && s_end_of_message;

    assign c    = s_char_code;
    assign d    = s_char_code[3:0];
    assign trim = is_trim_space(c);
    assign sep  = is_sep_space(c);
    assign dig  = is_digit(c);
    assign started = (pos_reg != POS_LEAD) || failed_reg;

    // one step of the pattern matcher
    always_comb begin
        ok      = 1'b0;
        adv_pos = pos_reg;
        adv_orp = orp_acc_reg;
        adv_ph  = ph_acc_reg;
        case (pos_reg)
            POS_LEAD: begin
                if (trim) begin
                    ok = 1'b1;
                end else if (c == CH_O) begin
                    ok = 1'b1; adv_pos = POS_R;
                end
            end
            POS_R:   if (c == CH_R) begin ok = 1'b1; adv_pos = POS_P; end
            POS_P:   if (c == CH_P) begin ok = 1'b1; adv_pos = POS_SL1; end
            POS_SL1: if (c == CH_SLASH) begin ok = 1'b1; adv_pos = POS_O1; end
            POS_O1: begin
                if (c >= CH_2 && c <= CH_9) begin
                    ok = 1'b1; adv_pos = POS_O2; adv_orp = {6'd0, d};
                end
            end
            POS_O2: begin
                if (dig) begin
                    ok = 1'b1; adv_pos = POS_O3;
                    adv_orp = 10'(orp_acc_reg * 10'd10) + {6'd0, d};
                end
            end
            POS_O3: begin
                if (dig) begin
                    ok = 1'b1; adv_pos = POS_O4;
                    adv_orp = 10'(orp_acc_reg * 10'd10) + {6'd0, d};
                end else if (sep) begin
                    ok = 1'b1; adv_pos = POS_SEP;
                end
            end
            POS_O4:  if (sep) begin ok = 1'b1; adv_pos = POS_SEP; end
            POS_SEP: begin
                if (sep) begin
                    ok = 1'b1;
                end else if (c == CH_P) begin
                    ok = 1'b1; adv_pos = POS_H;
                end
            end
            POS_H:   if (c == CH_H) begin ok = 1'b1; adv_pos = POS_SL2; end
            POS_SL2: if (c == CH_SLASH) begin ok = 1'b1; adv_pos = POS_PH1; end
            POS_PH1: begin
                if (c == CH_6) begin
                    ok = 1'b1; adv_pos = POS_DOT67; adv_ph = 10'd600;
                end else if (c == CH_7) begin
                    ok = 1'b1; adv_pos = POS_DOT67; adv_ph = 10'd700;
                end else if (c == CH_8) begin
                    ok = 1'b1; adv_pos = POS_DOT8; adv_ph = 10'd800;
                end
            end
            POS_DOT67: if (c == CH_DOT) begin ok = 1'b1; adv_pos = POS_F67; end
            POS_F67: begin
                if (dig) begin
                    ok = 1'b1; adv_pos = POS_DONE;
                    adv_ph = ph_acc_reg + 10'({6'd0, d} * 10'd10);
                end
            end
            POS_DOT8: if (c == CH_DOT) begin ok = 1'b1; adv_pos = POS_F8; end
            POS_F8: begin
                if (c == CH_0 || c == CH_1) begin
                    ok = 1'b1; adv_pos = POS_F8B;
                    adv_ph = ph_acc_reg + 10'({6'd0, d} * 10'd10);
                end else if (c == CH_2) begin
                    ok = 1'b1; adv_pos = POS_DONE; adv_ph = ph_acc_reg + 10'd20;
                end
            end
            POS_F8B: begin
                if (dig) begin
                    ok = 1'b1; adv_pos = POS_DONE; adv_ph = ph_acc_reg + {6'd0, d};
                end
            end
            POS_DONE: ok = trim;
            default:  ok = 1'b0;
        endcase
    end

    // trimmed length bookkeeping, parse update and result
    always_comb begin
        count_sum     = {1'b0, count_reg} + {1'b0, pending_reg} + 9'd1;
        pos_next      = pos_reg;
        failed_next   = failed_reg;
        orp_acc_next  = orp_acc_reg;
        ph_acc_next   = ph_acc_reg;
        count_next    = count_reg;
        pending_next  = pending_reg;
        good_orp_next = good_orp_reg;
        good_ph_next  = good_ph_reg;
        bad           = 1'b1;

        if (trim) begin
            if (started && pending_reg != COUNT_MAX) begin
                pending_next = pending_reg + 8'd1;
            end
        end else begin
            // pending trailing spaces turn out to be inner ones
            count_next   = count_sum[8] ? COUNT_MAX : count_sum[7:0];
            pending_next = 8'd0;
        end

        if (!failed_reg) begin
            if (ok) begin
                pos_next     = adv_pos;
                orp_acc_next = adv_orp;
                ph_acc_next  = adv_ph;
            end else begin
                failed_next = 1'b1;
            end
        end

        bad = failed_next || (pos_next != POS_DONE) || (count_next < min_length_reg) ||
              (count_next > max_length_reg);

        if (s_end_of_message && !bad) begin
            good_orp_next = orp_acc_next;
            good_ph_next  = ph_acc_next;
        end

        result.orp_millivolts = good_orp_next;
        result.ph_hundredths  = good_ph_next;
        result.malformed      = bad;

        if (s_end_of_message) begin
            pos_next     = POS_LEAD;
            failed_next  = 1'b0;
            orp_acc_next = 10'd0;
            ph_acc_next  = 10'd0;
            count_next   = 8'd0;
            pending_next = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MIN_LENGTH_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_MIN_LENGTH) begin
                min_length_reg <= cfg_data;
            end else begin
                max_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_LEAD;
            failed_reg   <= 1'b0;
            orp_acc_reg  <= 10'd0;
            ph_acc_reg   <= 10'd0;
            count_reg    <= 8'd0;
            pending_reg  <= 8'd0;
            good_orp_reg <= 10'd0;
            good_ph_reg  <= 10'd0;
        end else if (s_fire) begin
            pos_reg      <= pos_next;
            failed_reg   <= failed_next;
            orp_acc_reg  <= orp_acc_next;
            ph_acc_reg   <= ph_acc_next;
            count_reg    <= count_next;
            pending_reg  <= pending_next;
            good_orp_reg <= good_orp_next;
            good_ph_reg  <= good_ph_next;
        end
    end

    // result register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || emit;
            skid_valid_reg <= 1'b0;
        end else if (emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (emit) begin
                out_reg <= result;
            end
        end else if (emit) begin
            skid_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_orp_millivolts = out_reg.orp_millivolts;
    assign m_ph_hundredths  = out_reg.ph_hundredths;
    assign m_malformed      = out_reg.malformed;

endmodule

### hw/rtl/orp_checker.sv
// port-level checks for the orp/ph report parser, bound to the top level
module orp_checker
    import orp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_orp_millivolts,
    input logic [9:0] m_ph_hundredths,
    input logic       m_malformed
);

    // reset empties the result channel
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // a stalled result word is not dropped
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // the input only backs up when a result word is already waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with an empty result register");

    // values in a valid result word never exceed the accepted maxima
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_orp_millivolts <= ORP_MAX) && (m_ph_hundredths <= PH_MAX))
        else $error("result value out of range");

    // a good report carries real readings
    a_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_malformed |-> (m_orp_millivolts >= ORP_MIN) &&
                                    (m_ph_hundredths >= 10'd600))
        else $error("good result with impossible values");

endmodule

bind orp_ph_report_parser_unit orp_checker u_orp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_orp_millivolts (m_orp_millivolts),
    .m_ph_hundredths  (m_ph_hundredths),
    .m_malformed      (m_malformed)
);
